// ===== rtl/core/fifo_with_remove_by_value_macros.svh =====
// assertion macros for the fifo with remove by value
// no dependencies, included by the modules that check their own logic
`ifndef FIFO_WITH_REMOVE_BY_VALUE_MACROS_SVH
`define FIFO_WITH_REMOVE_BY_VALUE_MACROS_SVH

// same-cycle implication
`define FWR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fwr assertion failed");

// next-cycle implication
`define FWR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fwr assertion failed");

`endif

// ===== rtl/core/fwr_pkg.sv =====
// shared constants, operation and status codes and control types
// for the fifo with remove by value; no dependencies
package fwr_pkg;

    localparam int DEPTH      = 16;
    localparam int HANDLE_W   = 64;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // port field widths
    localparam int OP_W       = 2;
    localparam int HANDLE_IO_W = 64;
    localparam int STATUS_W   = 2;
    localparam int COUNT_IO_W = 5;
    localparam int OUT_W      = HANDLE_IO_W + STATUS_W + 1 + COUNT_IO_W;

    localparam logic [OP_W-1:0] OP_ENQ = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQ = 2'd1;
    localparam logic [OP_W-1:0] OP_REM = 2'd2;
    localparam logic [OP_W-1:0] OP_CLR = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic load;   // latch the accepted word and its match vector
        logic exec;   // carry out the operation and load the result register
    } t_dp_cmd;

endpackage

// ===== rtl/core/fwr_dpath.sv =====
// datapath: row of handle cells with per-cell compare, compaction shift,
// fill count and result register; uses fwr_pkg
`include "fifo_with_remove_by_value_macros.svh"

module fwr_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  fwr_pkg::t_dp_cmd                i_cmd,
    input  logic [fwr_pkg::OP_W-1:0]        i_op,
    input  logic [fwr_pkg::HANDLE_IO_W-1:0] i_handle,
    output logic [fwr_pkg::OUT_W-1:0]       o_data
);
    import fwr_pkg::*;

    logic [HANDLE_W-1:0]    r_cell [DEPTH];
    logic [HANDLE_W-1:0]    w_next [DEPTH];
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic [OP_W-1:0]        r_op;
    logic [HANDLE_W-1:0]    r_handle;
    logic [DEPTH-1:0]       r_match;
    logic [DEPTH-1:0]       n_match;
    logic [DEPTH-1:0]       w_prefix;
    logic [DEPTH-1:0]       w_shift;
    logic                   w_full;
    logic                   w_empty;
    logic                   w_found;
    logic                   w_do_enq;

    logic [HANDLE_IO_W-1:0] r_out_handle;
    logic [STATUS_W-1:0]    r_out_status;
    logic                   r_out_found;
    logic [COUNT_IO_W-1:0]  r_out_count;
    logic [HANDLE_IO_W-1:0] n_out_handle;
    logic [STATUS_W-1:0]    n_out_status;

    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_empty  = (r_count == '0);
    assign w_found  = |r_match;
    assign w_do_enq = (r_op == OP_ENQ) && !w_full;

    // compare every live cell against the incoming handle
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_match[i] = (CNT_W'(i) < r_count) &&
                         (r_cell[i] == i_handle[HANDLE_W-1:0]);
        end
    end

    // cells at and after the first match move one place toward the head
    always_comb begin
        logic acc;
        acc = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            acc         = acc | r_match[i];
            w_prefix[i] = acc;
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH - 1; i++) begin
            w_next[i] = r_cell[i + 1];
        end
        w_next[DEPTH-1] = r_cell[DEPTH-1];
    end

    always_comb begin
        w_shift      = '0;
        n_count      = r_count;
        n_out_handle = '0;
        n_out_status = ST_OK;
        unique case (r_op)
            OP_ENQ: begin
                if (w_full) begin
                    n_out_status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            OP_DEQ: begin
                if (w_empty) begin
                    n_out_status = ST_EMPTY;
                end else begin
                    w_shift      = '1;
                    n_count      = r_count - 1'b1;
                    n_out_handle = HANDLE_IO_W'(r_cell[0]);
                end
            end
            OP_REM: begin
                w_shift = w_prefix;
                if (w_found) begin
                    n_count = r_count - 1'b1;
                end
            end
            OP_CLR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_op;
            r_handle <= i_handle[HANDLE_W-1:0];
            r_match  <= n_match;
        end
        if (i_cmd.exec) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (w_shift[i]) begin
                    r_cell[i] <= w_next[i];
                end else if (w_do_enq && (IDX_W'(i) == r_count[IDX_W-1:0])) begin
                    r_cell[i] <= r_handle;
                end
            end
            r_out_handle <= n_out_handle;
            r_out_status <= n_out_status;
            r_out_found  <= (r_op == OP_REM) && w_found;
            r_out_count  <= COUNT_IO_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    assign o_data = {r_out_count, r_out_found, r_out_status, r_out_handle};

    `FWR_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `FWR_ASSERT_NEXT(a_rem_shrinks, i_clk, i_rst_n, i_cmd.exec && r_op == OP_REM && w_found, r_count == $past(r_count) - 1'b1)
    `FWR_ASSERT_NEXT(a_enq_grows, i_clk, i_rst_n, i_cmd.exec && r_op == OP_ENQ && !w_full, r_count == $past(r_count) + 1'b1)

endmodule

// ===== rtl/core/fwr_ctrl.sv =====
// controller: two-state sequencer that accepts a word, runs it once the
// result register is free, and tracks result valid; uses fwr_pkg
`include "fifo_with_remove_by_value_macros.svh"

module fwr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output fwr_pkg::t_dp_cmd o_cmd
);
    import fwr_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic w_load;
    logic w_exec;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_load     = i_in_valid && o_in_ready;
    // result register is free or being emptied this cycle
    assign w_exec     = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_load) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_exec) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_exec) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd.load  = w_load;
    assign o_cmd.exec  = w_exec;

    `FWR_ASSERT_NEXT(a_load_to_exec, i_clk, i_rst_n, w_load, r_state == S_EXEC)
    `FWR_ASSERT_NEXT(a_exec_gives_word, i_clk, i_rst_n, w_exec, r_out_valid && r_state == S_IDLE)
    `FWR_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_state == S_EXEC && r_out_valid && !i_out_ready, r_state == S_EXEC)

endmodule

// ===== rtl/core/fifo_with_remove_by_value.sv =====
// fifo of handle words with remove by value: one word in, one word out.
// the input word and its match vector are latched when the word is accepted; compaction,
// count update and the result register load follow in the execute state, and no new word is
// accepted until then (the compare-then-shift step over the cell row is split in these two).
// a stalled result word holds the sequencer until the result register frees up.
// reset (i_rst_n low, synchronous) empties the queue and drops any pending result.
module fifo_with_remove_by_value (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [fwr_pkg::HANDLE_IO_W-1:0] s_axis_tdata,   // handle_in
    input  logic [fwr_pkg::OP_W-1:0]        s_axis_tuser,   // op
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [fwr_pkg::OUT_W-1:0]       m_axis_tdata    // handle_out, status, found, count
);
    import fwr_pkg::*;

    t_dp_cmd w_cmd;

    fwr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    fwr_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_op     (s_axis_tuser),
        .i_handle (s_axis_tdata),
        .o_data   (m_axis_tdata)
    );

endmodule

// ===== dv/fifo_with_remove_by_value_test.sv =====
// testbench for the handle fifo with remove by value: scoreboard class, stream drivers, checks
// depends on fwr_pkg and the fifo_with_remove_by_value top level
`timescale 1ns / 1ps

module fifo_with_remove_by_value_test;
    import fwr_pkg::*;

    // result word as packed on m_axis_tdata, handle in the low bits
    typedef struct packed {
        logic [COUNT_IO_W-1:0]  count;
        logic                   found;
        logic [STATUS_W-1:0]    status;
        logic [HANDLE_IO_W-1:0] handle;
    } t_fwr_result;

    class fwr_scoreboard;
        logic [HANDLE_IO_W-1:0] held[$];    // predicted queue contents, head first
        t_fwr_result            pending_results[$];
        int unsigned            errors = 0;
        int unsigned            results_checked = 0;
        int unsigned            full_refusals = 0;
        int unsigned            empty_dequeues = 0;
        int unsigned            remove_hits = 0;
        int unsigned            remove_misses = 0;
        int unsigned            clears = 0;

        function void note_word(logic [OP_W-1:0] op, logic [HANDLE_IO_W-1:0] h);
            t_fwr_result r;
            int i;
            r = '0;
            r.status = ST_OK;
            case (op)
                OP_ENQ: begin
                    if (held.size() >= DEPTH) begin
                        r.status = ST_FULL;
                        full_refusals++;
                    end else begin
                        held.push_back(h);
                    end
                end
                OP_DEQ: begin
                    if (held.size() == 0) begin
                        r.status = ST_EMPTY;
                        empty_dequeues++;
                    end else begin
                        r.handle = held.pop_front();
                    end
                end
                OP_REM: begin
                    // only the match nearest the head goes
                    for (i = 0; i < held.size(); i++) begin
                        if (held[i] == h) begin
                            held.delete(i);
                            r.found = 1'b1;
                            break;
                        end
                    end
                    if (r.found) remove_hits++;
                    else remove_misses++;
                end
                default: begin
                    held.delete();
                    clears++;
                end
            endcase
            r.count = COUNT_IO_W'(held.size());
            pending_results.push_back(r);
        endfunction

        function void report(string what, t_fwr_result want, t_fwr_result got);
            errors++;
            if (errors <= 10)
                $display({"%0t %s: expected handle %h status %0d found %0d count %0d, ",
                          "got handle %h status %0d found %0d count %0d"},
                         $realtime, what, want.handle, want.status, want.found, want.count,
                         got.handle, got.status, got.found, got.count);
        endfunction

        function void check_word(logic [OUT_W-1:0] word);
            t_fwr_result got;
            t_fwr_result want;
            got = word;
            results_checked++;
            if (pending_results.size() == 0) begin
                report("result word with nothing pending", '0, got);
                return;
            end
            want = pending_results.pop_front();
            if (got.handle !== want.handle || got.status !== want.status ||
                got.found !== want.found || got.count !== want.count)
                report("result mismatch", want, got);
        endfunction

        function void close_out();
            while (pending_results.size() != 0)
                report("result never arrived", pending_results.pop_front(), '0);
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [HANDLE_IO_W-1:0] s_axis_tdata = '0;     // handle_in
    logic [OP_W-1:0]        s_axis_tuser = OP_ENQ; // op
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_W-1:0]       m_axis_tdata;          // handle_out, status, found, count

    fwr_scoreboard sb = new();

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_req = 1'b0;
    int unsigned words_sent = 0;

    logic [HANDLE_IO_W-1:0] handle_pool [6] = '{
        64'h0, 64'hffff_ffff_ffff_ffff, 64'h1, 64'h8000_0000_0000_0000,
        64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210
    };

    fifo_with_remove_by_value DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // result side: check at the rising edge, pick tready at the falling edge
    initial begin : result_sink
        int unsigned hold_left;
        int unsigned stall_now;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_word(m_axis_tdata);
            stall_now = recv_stall_pct;
            if (hold_req && !hold_done) begin
                hold_left = 300;
                hold_done = 1'b1;
            end
            @(negedge i_clk);
            if (hold_left != 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= stall_now);
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_word(logic [OP_W-1:0] op, logic [HANDLE_IO_W-1:0] h);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= h;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_word(op, h);
        words_sent++;
        @(negedge i_clk);
    endtask

    // removes mostly look for something that is held, so hits are common
    function automatic logic [HANDLE_IO_W-1:0] pick_handle(bit for_remove);
        int unsigned r;
        r = $urandom_range(99);
        if (sb.held.size() != 0 && r < (for_remove ? 60 : 15))
            return sb.held[$urandom_range(sb.held.size() - 1)];
        if (r < 70)
            return handle_pool[$urandom_range(5)];
        return {$urandom, $urandom};
    endfunction

    task automatic run_random(int unsigned n, bit with_hold);
        int unsigned     k;
        int unsigned     r;
        logic [OP_W-1:0] op;
        for (k = 0; k < n; k++) begin
            if (with_hold && k == 120)
                hold_req = 1'b1;
            r = $urandom_range(99);
            // alternate stretches that fill the queue up and drain it down
            if ((k / 60) % 2 == 0) begin
                if (r < 62)      op = OP_ENQ;
                else if (r < 77) op = OP_DEQ;
                else if (r < 98) op = OP_REM;
                else             op = OP_CLR;
            end else begin
                if (r < 25)      op = OP_ENQ;
                else if (r < 62) op = OP_DEQ;
                else if (r < 98) op = OP_REM;
                else             op = OP_CLR;
            end
            send_word(op, pick_handle(op == OP_REM));
        end
    endtask

    initial begin : stimulus
        int unsigned i;
        int unsigned waited;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty queue corner cases
        send_word(OP_DEQ, 64'hffff_ffff_ffff_ffff);
        send_word(OP_CLR, 64'h0);
        send_word(OP_REM, 64'h0);
        // fill to the brim, with a duplicate, then one more is refused
        send_word(OP_ENQ, 64'hffff_ffff_ffff_ffff);
        send_word(OP_ENQ, 64'h0);
        send_word(OP_ENQ, 64'h5555_5555_5555_5555);
        send_word(OP_ENQ, 64'haaaa_aaaa_aaaa_aaaa);
        send_word(OP_ENQ, 64'h0);
        send_word(OP_ENQ, 64'h1);
        send_word(OP_ENQ, 64'h8000_0000_0000_0000);
        for (i = 0; i < DEPTH - 7; i++)
            send_word(OP_ENQ, {$urandom, $urandom});
        send_word(OP_ENQ, 64'h1234_5678_9abc_def0);
        send_word(OP_REM, 64'h0);
        send_word(OP_REM, 64'hdead_beef_0bad_f00d);
        send_word(OP_DEQ, 64'h0);
        send_word(OP_DEQ, 64'h0);
        send_word(OP_CLR, 64'hffff_ffff_ffff_ffff);
        send_word(OP_DEQ, 64'h0);

        send_idle_pct = 0;  recv_stall_pct = 0;
        run_random(335, 1'b1);
        send_idle_pct = 58; recv_stall_pct = 0;
        run_random(335, 1'b0);
        send_idle_pct = 0;  recv_stall_pct = 58;
        run_random(335, 1'b0);
        send_idle_pct = 37; recv_stall_pct = 37;
        run_random(335, 1'b0);
        s_axis_tvalid <= 1'b0;

        waited = 0;
        while (sb.pending_results.size() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        sb.close_out();

        $display("%0d words sent, %0d results checked, %0d mismatches",
                 words_sent, sb.results_checked, sb.errors);
        $display("full refusals %0d, empty dequeues %0d, remove hits %0d, misses %0d, clears %0d",
                 sb.full_refusals, sb.empty_dequeues, sb.remove_hits, sb.remove_misses,
                 sb.clears);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
